[rtl/cfd_pkg.sv]
package cfd_pkg;

  localparam int PAYLOAD_DEPTH_DEF = 256;

  localparam logic [7:0]  MAGIC_FIRST  = 8'h41;
  localparam logic [7:0]  MAGIC_SECOND = 8'h4B;
  localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;

  localparam logic ACT_FEED  = 1'b0;
  localparam logic ACT_READ  = 1'b1;
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TYPE_LOW     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TYPE_HIGH    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TYPE_MASK    = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_SHIFT = 2'd3;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
    logic [7:0] read_index;
  } cfd_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  type_code;
    logic [7:0]  frame_target;
    logic [15:0] transfer_number;
    logic [15:0] sequence_number;
    logic [7:0]  payload_length;
    logic [7:0]  read_data;
  } cfd_result_t;

  typedef struct packed {
    logic [7:0] type_low;
    logic [7:0] type_high;
    logic [7:0] type_mask;
    logic [2:0] target_shift;
  } cfd_cfg_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } cfd_wr_t;

  // Reflected CRC-32 advanced by one byte, all eight bit steps unrolled.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/crc32_frame_deframer_unit.sv]
// Channel   Signals                                   Moves
// item      item_valid / item_ready / item           one link byte or one payload read
// result    result_valid / result_ready / result     good-frame summary or read data
// cfg       cfg_valid / cfg_ready / cfg_index / cfg_data   one register write
//
// One item is accepted per cycle while item_ready is high; the CRC byte update and
// the payload write finish in the accept cycle. A result is registered in the read
// stage, alongside the payload memory read, and then in the output register.
// Reset is synchronous and clears the parse state and accepted length; the
// payload memory is not cleared. When the result register is full and stalled,
// one more result can wait in the read stage before item_ready drops.
module crc32_frame_deframer_unit
  import cfd_pkg::*;
#(
  parameter int PAYLOAD_DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  cfd_item_t              item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output cfd_result_t            result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data
);

  localparam logic [8:0] DEPTH_V = 9'(PAYLOAD_DEPTH);

  cfd_cfg_t    cfg;
  cfd_wr_t     wr;
  logic        frame_good;
  cfd_result_t frame_res;
  logic [7:0]  accepted_length;
  logic [7:0]  rd_data;

  logic        acc;
  logic        is_read;
  logic        rd_ok;
  logic        s1_valid;
  logic        s1_rd_ok;
  cfd_result_t s1_res;
  cfd_result_t s1_out;
  cfd_result_t read_res;
  logic        s1_load;
  logic        s1_adv;

  assign acc     = item_valid && item_ready;
  assign is_read = (item.action == ACT_READ);
  assign rd_ok   = (item.read_index < accepted_length) && ({1'b0, item.read_index} < DEPTH_V);

  cfd_config_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cfd_parser u_parser (
    .clk             (clk),
    .rst             (rst),
    .feed            (acc && !is_read),
    .rx_byte         (item.rx_byte),
    .cfg             (cfg),
    .wr              (wr),
    .frame_good      (frame_good),
    .frame_res       (frame_res),
    .accepted_length (accepted_length)
  );

  cfd_payload_mem #(
    .DEPTH (PAYLOAD_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (acc && is_read),
    .rd_addr (item.read_index),
    .rd_data (rd_data)
  );

  always_comb begin
    read_res             = '0;
    read_res.result_kind = KIND_READ;
  end

  always_comb begin
    s1_out           = s1_res;
    s1_out.read_data = s1_rd_ok ? rd_data : 8'd0;
  end

  assign s1_load    = acc && (is_read || frame_good);
  assign s1_adv     = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_res   <= is_read ? read_res : frame_res;
      s1_rd_ok <= is_read && rd_ok;
    end
    if (s1_adv) begin
      result <= s1_out;
    end
  end

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(acc && s1_valid && !s1_adv))
    else $error("item accepted while the read stage was full and stalled");

  a_read_fields_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.result_kind == KIND_READ) |->
      (result.type_code == 8'd0) && (result.transfer_number == 16'd0) &&
      (result.sequence_number == 16'd0) && (result.payload_length == 8'd0))
    else $error("read result carries frame fields");

  a_frame_no_data: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.result_kind == KIND_FRAME) |-> (result.read_data == 8'd0))
    else $error("frame result carries read data");
`endif

endmodule

[rtl/cfd_config_regs.sv]
module cfd_config_regs
  import cfd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]             cfg_data,
  output cfd_cfg_t               cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.type_low     <= 8'd1;
      cfg.type_high    <= 8'd4;
      cfg.type_mask    <= 8'd15;
      cfg.target_shift <= 3'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TYPE_LOW:     cfg.type_low     <= cfg_data;
        CFG_TYPE_HIGH:    cfg.type_high    <= cfg_data;
        CFG_TYPE_MASK:    cfg.type_mask    <= cfg_data;
        CFG_TARGET_SHIFT: cfg.target_shift <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/cfd_payload_mem.sv]
module cfd_payload_mem
  import cfd_pkg::*;
#(
  parameter int DEPTH = PAYLOAD_DEPTH_DEF
) (
  input  logic       clk,
  input  cfd_wr_t    wr,
  input  logic       rd_en,
  input  logic [7:0] rd_addr,
  output logic [7:0] rd_data
);

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [8:0] DEPTH_V = 9'(DEPTH);

  logic [7:0] mem [DEPTH];

  // Bytes beyond the store still pass through the CRC but are not kept.
  always_ff @(posedge clk) begin
    if (wr.en && ({1'b0, wr.addr} < DEPTH_V)) begin
      mem[wr.addr[ADDR_W-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

endmodule

[rtl/cfd_parser.sv]
module cfd_parser
  import cfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        feed,
  input  logic [7:0]  rx_byte,
  input  cfd_cfg_t    cfg,
  output cfd_wr_t     wr,
  output logic        frame_good,
  output cfd_result_t frame_res,
  output logic [7:0]  accepted_length
);

  localparam logic [2:0] PH_MAGIC0  = 3'd0;
  localparam logic [2:0] PH_MAGIC1  = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CRC     = 3'd4;

  logic [2:0]  phase;
  logic [7:0]  pos;
  logic [31:0] crc;
  logic [31:0] rcrc;
  logic [7:0]  type_byte;
  logic [15:0] tid;
  logic [15:0] seq;
  logic [7:0]  len;

  logic [8:0]  pos_inc;
  logic [31:0] crc_next;
  logic [31:0] rcrc_next;
  logic [7:0]  type_dec;
  logic        type_ok;

  assign pos_inc   = {1'b0, pos} + 9'd1;
  assign crc_next  = crc_byte(crc, rx_byte);
  assign rcrc_next = {rx_byte, rcrc[31:8]};
  assign type_dec  = type_byte & cfg.type_mask;
  assign type_ok   = (type_dec >= cfg.type_low) && (type_dec <= cfg.type_high);

  assign wr.en   = feed && (phase == PH_PAYLOAD);
  assign wr.addr = pos;
  assign wr.data = rx_byte;

  assign frame_good = feed && (phase == PH_CRC) && (pos_inc >= 9'd4) && (rcrc_next == ~crc);

  always_comb begin
    frame_res                 = '0;
    frame_res.result_kind     = KIND_FRAME;
    frame_res.type_code       = type_dec;
    frame_res.frame_target    = type_byte >> cfg.target_shift;
    frame_res.transfer_number = tid;
    frame_res.sequence_number = seq;
    frame_res.payload_length  = len;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_MAGIC0;
      pos             <= '0;
      crc             <= CRC_INIT;
      rcrc            <= '0;
      accepted_length <= '0;
    end else if (feed) begin
      case (phase)
        PH_MAGIC1: begin
          if (rx_byte == MAGIC_SECOND) begin
            phase <= PH_HEADER;
            pos   <= 8'd2;
            crc   <= CRC_INIT;
          end else if (rx_byte != MAGIC_FIRST) begin
            phase <= PH_MAGIC0;
            pos   <= '0;
          end
        end
        PH_HEADER: begin
          crc <= crc_next;
          case (pos[2:0])
            3'd2:    type_byte  <= rx_byte;
            3'd3:    tid[7:0]   <= rx_byte;
            3'd4:    tid[15:8]  <= rx_byte;
            3'd5:    seq[7:0]   <= rx_byte;
            3'd6:    seq[15:8]  <= rx_byte;
            3'd7:    len        <= rx_byte;
            default: ;
          endcase
          // The type byte is already held when the length byte closes the header.
          if (pos_inc >= 9'd8) begin
            pos <= '0;
            if (!type_ok) begin
              phase <= PH_MAGIC0;
            end else begin
              accepted_length <= '0;
              rcrc            <= '0;
              phase           <= (rx_byte != 8'd0) ? PH_PAYLOAD : PH_CRC;
            end
          end else begin
            pos <= pos_inc[7:0];
          end
        end
        PH_PAYLOAD: begin
          crc <= crc_next;
          if (pos_inc >= {1'b0, len}) begin
            pos   <= '0;
            rcrc  <= '0;
            phase <= PH_CRC;
          end else begin
            pos <= pos_inc[7:0];
          end
        end
        PH_CRC: begin
          rcrc <= rcrc_next;
          if (pos_inc >= 9'd4) begin
            phase <= PH_MAGIC0;
            pos   <= '0;
            if (frame_good) begin
              accepted_length <= len;
            end
          end else begin
            pos <= pos_inc[7:0];
          end
        end
        default: begin
          phase <= (rx_byte == MAGIC_FIRST) ? PH_MAGIC1 : PH_MAGIC0;
        end
      endcase
    end
  end

endmodule
